// ===== design/error_diffusion_halftone_core_macros.svh =====
// ----------------------------------------------------------------------------
// error diffusion halftone core: assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ERROR_DIFFUSION_HALFTONE_CORE_MACROS_SVH
`define ERROR_DIFFUSION_HALFTONE_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define EDH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EDH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define EDH_ASSERT_IMP(lbl, ante, cons, msg)
`define EDH_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/edh_pkg.sv =====
// ----------------------------------------------------------------------------
// edh_pkg
// Types, widths and constants shared by the error diffusion halftone core.
// ----------------------------------------------------------------------------
`default_nettype none

package edh_pkg;

  // line store geometry and error precision
  localparam int MAX_WIDTH  = 1024;
  localparam int ERROR_BITS = 12;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int WID_W      = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
  localparam int POS_W      = WID_W + 1;

  // field widths
  localparam int PIX_W  = 8;
  localparam int COL_W  = 10;
  localparam int DIR_W  = 2;
  localparam int RND_W  = 8;
  localparam int LVL_W  = 8;
  localparam int LWID_W = 11;

  // datapath widths
  localparam int ERR_W   = ERROR_BITS + 1;
  localparam int WT_W    = 13;
  localparam int FRAC_W  = 12;
  localparam int PROD_W  = ERR_W + WT_W;
  localparam int SHARE_W = PROD_W - FRAC_W;
  localparam int SUM_W   = SHARE_W + 1;
  localparam int N_W     = ERR_W + LVL_W + 2;
  localparam int DVD_W   = 2 * LVL_W;

  // configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam logic [1:0] REG_LEVELS     = 2'd0;
  localparam logic [1:0] REG_LINE_WIDTH = 2'd1;
  localparam logic [1:0] REG_RANDOM     = 2'd2;

  localparam logic [LVL_W-1:0]  LEVELS_RST = LVL_W'(1);
  localparam logic [LWID_W-1:0] LWID_RST   = LWID_W'(1024);

  // diffusion weights in 1/4096 units
  localparam logic signed [WT_W-1:0] W1_BASE = WT_W'(256);
  localparam logic signed [WT_W-1:0] W3_BASE = WT_W'(768);
  localparam logic signed [WT_W-1:0] W5_BASE = WT_W'(1280);
  localparam logic signed [WT_W-1:0] W7_BASE = WT_W'(1792);

  localparam int QUANT_BIAS = 127;
  localparam int FULL_SCALE = 255;

  // divider: two quotient bits per cycle
  localparam int DIV_STEPS  = 2;
  localparam int DIV_CYCLES = LVL_W / DIV_STEPS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_QNT,
    ST_QV,
    ST_DIV,
    ST_SP0,
    ST_SP1,
    ST_SP2,
    ST_SP3,
    ST_SP4
  } edh_state_t;

  typedef struct packed {
    logic             start;
    logic [LVL_W-1:0] v;
    logic [LVL_W-1:0] lv;
  } edh_div_req_t;

  typedef struct packed {
    logic             done;
    logic [LVL_W-1:0] quot;
  } edh_div_rsp_t;

endpackage

`default_nettype wire

// ===== design/edh_stream_if.sv =====
// ----------------------------------------------------------------------------
// edh stream interfaces
// Valid/ready channels for pixel items in and quantized levels out.
// ----------------------------------------------------------------------------
`default_nettype none

interface edh_in_if import edh_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [PIX_W-1:0]        pixel;
  logic [COL_W-1:0]        column;
  logic signed [DIR_W-1:0] direction;
  logic                    new_line;
  logic signed [RND_W-1:0] rand_a;
  logic signed [RND_W-1:0] rand_b;

  modport source (output valid, pixel, column, direction, new_line, rand_a, rand_b,
                  input ready);
  modport sink (input valid, pixel, column, direction, new_line, rand_a, rand_b,
                output ready);
endinterface

interface edh_out_if import edh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LVL_W-1:0] level;

  modport source (output valid, level, input ready);
  modport sink (input valid, level, output ready);
endinterface

`default_nettype wire

// ===== design/edh_ram.sv =====
// ----------------------------------------------------------------------------
// edh_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module edh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/edh_div.sv =====
// ----------------------------------------------------------------------------
// edh_div
// Restoring divider for v*255/levels, two quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "error_diffusion_halftone_core_macros.svh"

module edh_div import edh_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  edh_div_req_t req,
  output edh_div_rsp_t rsp
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [LVL_W-1:0]     rem_r;
  logic [LVL_W-1:0]     low_r;
  logic [LVL_W-1:0]     lv_r;
  logic [LVL_W-1:0]     v_r;
  logic [DVD_W-1:0]     dvd;
  logic [DVD_W-1:0]     dvd_chk;
  logic [DVD_W-1:0]     prod_chk;
  logic [LVL_W-1:0]     rem_nxt;
  logic [LVL_W-1:0]     low_nxt;

  // v*255 as a shift and subtract
  assign dvd     = {req.v, LVL_W'(0)} - DVD_W'(req.v);
  assign dvd_chk = {v_r, LVL_W'(0)} - DVD_W'(v_r);
  assign prod_chk = DVD_W'(low_r) * DVD_W'(lv_r);

  // quotient fits in LVL_W bits, so the upper half starts as the remainder
  always_comb begin
    logic [LVL_W:0] t;
    logic [LVL_W:0] d;
    logic           qb;
    rem_nxt = rem_r;
    low_nxt = low_r;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t       = {rem_nxt, low_nxt[LVL_W-1]};
      d       = t - {1'b0, lv_r};
      qb      = (t >= {1'b0, lv_r});
      rem_nxt = qb ? d[LVL_W-1:0] : t[LVL_W-1:0];
      low_nxt = {low_nxt[LVL_W-2:0], qb};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DIV_CYCLES - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= dvd[DVD_W-1:LVL_W];
      low_r <= dvd[LVL_W-1:0];
      lv_r  <= req.lv;
      v_r   <= req.v;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = low_r;

  `EDH_ASSERT_IMP(a_div_quot_low, done_r, prod_chk <= dvd_chk, "quotient too large")
  `EDH_ASSERT_IMP(a_div_quot_high, done_r, (dvd_chk - prod_chk) < DVD_W'(lv_r), "quotient too small")
  `EDH_ASSERT_IMP(a_div_no_restart, req.start, !busy_r, "divider restarted while busy")

endmodule

`default_nettype wire

// ===== design/error_diffusion_halftone_core.sv =====
// ----------------------------------------------------------------------------
// error_diffusion_halftone_core
// Serpentine error-diffusion halftoner over two line stores in block RAM.
// Sequence: line-store reads, quantiser, divider; then the level is registered
//   (held while the output stalls) and the error is spread over four updates,
//   three via the next-row store's one write port, before a new pixel is taken.
// Reset: registers return to defaults, then a clearing pass zeroes both line
//   stores; no pixel is taken until it ends, config is always taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "error_diffusion_halftone_core_macros.svh"

module error_diffusion_halftone_core import edh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  edh_in_if.sink            in_ch,
  edh_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam logic signed [SUM_W-1:0]  ERR_MAX   = SUM_W'((1 <<< (ERROR_BITS - 1)) - 1);
  localparam logic signed [SUM_W-1:0]  ERR_MIN   = SUM_W'(-(1 <<< (ERROR_BITS - 1)));
  localparam logic [PROD_W-1:0]        FRAC_MASK = PROD_W'((1 << FRAC_W) - 1);
  localparam logic [N_W-1:0]           QUOT_LIM  = N_W'(FULL_SCALE << LVL_W);

  // configuration registers
  logic [LVL_W-1:0]  levels_r;
  logic [LWID_W-1:0] line_width_r;
  logic              random_r;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;

  // control
  edh_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic              row_sel_r;
  logic              out_valid_r;
  logic [LVL_W-1:0]  out_level_r;
  logic              in_xfer;
  logic              push;

  // item payload
  logic [PIX_W-1:0]        pix_r;
  logic [COL_W-1:0]        col_r;
  logic                    left_r;
  logic signed [WT_W-1:0]  w1_r, w3_r, w5_r, w7_r;
  logic signed [ERR_W-1:0] pix_sum_r;
  logic signed [N_W-1:0]   n_r;
  logic [LVL_W-1:0]        v_r;
  logic signed [ERR_W-1:0] err_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [ERROR_BITS-1:0]   e_c7_r, e_n1_r, e_n5_r, e_n3_r;

  // derived
  logic [LVL_W-1:0]        lv_eff;
  logic [WID_W-1:0]        width_eff;
  logic [WID_W-1:0]        lw_ext;
  logic [POS_W-1:0]        col_pos, dir_pos, fwd_pos, bwd_pos;
  logic                    col_ok, fwd_ok, bwd_ok;
  logic [ADDR_W-1:0]       col_a, fwd_a, bwd_a;
  logic signed [WT_W-1:0]  ra_x, rb_x, rb5;
  logic [LVL_W-1:0]        v_nxt;
  logic [2*LVL_W:0]        q17;
  logic [3*LVL_W:0]        qp;
  logic [LVL_W-1:0]        q8;
  logic signed [WT_W-1:0]  w_sel;
  logic [ERROR_BITS-1:0]   old_sel;
  logic [PROD_W-1:0]       biased;
  logic signed [SHARE_W-1:0] share;
  logic [ERROR_BITS-1:0]   upd;

  // logical line-store ports, current and next row
  logic                  cur_we, nxt_we;
  logic [ADDR_W-1:0]     cur_waddr, nxt_waddr, cur_raddr, nxt_raddr;
  logic [ERROR_BITS-1:0] cur_wdata, nxt_wdata, cur_rdata, nxt_rdata;

  // physical RAM ports
  logic                  a_we, b_we;
  logic [ADDR_W-1:0]     a_waddr, b_waddr, a_raddr, b_raddr;
  logic [ERROR_BITS-1:0] a_wdata, b_wdata, a_rdata, b_rdata;

  edh_div_req_t div_req;
  edh_div_rsp_t div_rsp;

  function automatic logic in_row(logic [POS_W-1:0] pos, logic [WID_W-1:0] wid);
    return !pos[POS_W-1] && (pos[WID_W-1:0] < wid);
  endfunction

  function automatic logic [ERROR_BITS-1:0] sat_add(logic [ERROR_BITS-1:0] old,
                                                    logic signed [SHARE_W-1:0] sh);
    logic signed [SUM_W-1:0] sum;
    sum = SUM_W'($signed(old)) + SUM_W'(sh);
    if (sum > ERR_MAX) begin
      sum = ERR_MAX;
    end else if (sum < ERR_MIN) begin
      sum = ERR_MIN;
    end
    return sum[ERROR_BITS-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r     <= LEVELS_RST;
      line_width_r <= LWID_RST;
      random_r     <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LEVELS:     levels_r     <= pwdata[LVL_W-1:0];
        REG_LINE_WIDTH: line_width_r <= pwdata[LWID_W-1:0];
        REG_RANDOM:     random_r     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LEVELS:     prdata = CFG_DW'(levels_r);
      REG_LINE_WIDTH: prdata = CFG_DW'(line_width_r);
      REG_RANDOM:     prdata = CFG_DW'(random_r);
      default:        prdata = '0;
    endcase
  end

  // zero levels acts as one; width limited to 1..MAX_WIDTH
  assign lv_eff = (levels_r == '0) ? LVL_W'(1) : levels_r;
  assign lw_ext = WID_W'(line_width_r);

  always_comb begin
    if (lw_ext > WID_W'(MAX_WIDTH)) begin
      width_eff = WID_W'(MAX_WIDTH);
    end else if (lw_ext == '0) begin
      width_eff = WID_W'(1);
    end else begin
      width_eff = lw_ext;
    end
  end

  // --------------------------------------------------------------------------
  // item capture
  // --------------------------------------------------------------------------
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid & in_ch.ready;

  assign ra_x = WT_W'(in_ch.rand_a);
  assign rb_x = WT_W'(in_ch.rand_b);
  assign rb5  = (rb_x <<< 2) + rb_x;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pix_r  <= in_ch.pixel;
      col_r  <= in_ch.column;
      left_r <= in_ch.direction[DIR_W-1];
      w1_r   <= random_r ? W1_BASE + ra_x : W1_BASE;
      w3_r   <= random_r ? W3_BASE - ra_x : W3_BASE;
      w5_r   <= random_r ? W5_BASE + rb5 : W5_BASE;
      w7_r   <= random_r ? W7_BASE - rb5 : W7_BASE;
    end
  end

  // neighbour positions along the scan
  assign col_pos = POS_W'(col_r);
  assign dir_pos = left_r ? '1 : POS_W'(1);
  assign fwd_pos = col_pos + dir_pos;
  assign bwd_pos = col_pos - dir_pos;
  assign col_ok  = in_row(col_pos, width_eff);
  assign fwd_ok  = col_ok && in_row(fwd_pos, width_eff);
  assign bwd_ok  = col_ok && in_row(bwd_pos, width_eff);
  assign col_a   = col_pos[ADDR_W-1:0];
  assign fwd_a   = fwd_pos[ADDR_W-1:0];
  assign bwd_a   = bwd_pos[ADDR_W-1:0];

  // --------------------------------------------------------------------------
  // quantiser: v = min(levels, (p*levels+127)/255), clamped at zero
  // --------------------------------------------------------------------------
  assign q17 = {1'b0, n_r[2*LVL_W-1:0]} + (2*LVL_W+1)'(1);
  assign qp  = {q17, LVL_W'(0)} + (3*LVL_W+1)'(q17);
  assign q8  = qp[3*LVL_W-1:2*LVL_W];

  always_comb begin
    if (n_r[N_W-1]) begin
      v_nxt = '0;
    end else if ($unsigned(n_r) >= QUOT_LIM) begin
      v_nxt = lv_eff;
    end else if (q8 > lv_eff) begin
      v_nxt = lv_eff;
    end else begin
      v_nxt = q8;
    end
  end

  assign div_req.start = (state_r == ST_QV);
  assign div_req.v     = v_nxt;
  assign div_req.lv    = lv_eff;

  edh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // --------------------------------------------------------------------------
  // error spreading: one product per cycle, written back the cycle after
  // --------------------------------------------------------------------------
  always_comb begin
    case (state_r)
      ST_SP0:  w_sel = w7_r;
      ST_SP1:  w_sel = w1_r;
      ST_SP2:  w_sel = w5_r;
      default: w_sel = w3_r;
    endcase
  end

  always_comb begin
    case (state_r)
      ST_SP1:  old_sel = e_c7_r;
      ST_SP2:  old_sel = e_n1_r;
      ST_SP3:  old_sel = e_n5_r;
      default: old_sel = e_n3_r;
    endcase
  end

  // truncate toward zero
  assign biased = prod_r + (prod_r[PROD_W-1] ? FRAC_MASK : '0);
  assign share  = biased[PROD_W-1:FRAC_W];
  assign upd    = sat_add(old_sel, share);

  assign push = (state_r == ST_DIV) && div_rsp.done && (!out_valid_r || out_ch.ready);

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    cur_we    = 1'b0;
    nxt_we    = 1'b0;
    cur_waddr = col_a;
    nxt_waddr = col_a;
    cur_wdata = upd;
    nxt_wdata = upd;
    cur_raddr = col_a;
    nxt_raddr = col_a;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == ADDR_W'(MAX_WIDTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_RD0;
        end
      end
      ST_RD0: begin
        nxt_raddr = fwd_a;
        state_nxt = ST_RD1;
      end
      ST_RD1: begin
        // the error for this column is used once, then cleared
        cur_raddr = fwd_a;
        cur_we    = col_ok;
        cur_wdata = '0;
        state_nxt = ST_QNT;
      end
      ST_QNT: begin
        nxt_raddr = bwd_a;
        state_nxt = ST_QV;
      end
      ST_QV: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (push) begin
          state_nxt = ST_SP0;
        end
      end
      ST_SP0: begin
        state_nxt = ST_SP1;
      end
      ST_SP1: begin
        cur_we    = fwd_ok;
        cur_waddr = fwd_a;
        state_nxt = ST_SP2;
      end
      ST_SP2: begin
        nxt_we    = fwd_ok;
        nxt_waddr = fwd_a;
        state_nxt = ST_SP3;
      end
      ST_SP3: begin
        nxt_we    = col_ok;
        state_nxt = ST_SP4;
      end
      ST_SP4: begin
        nxt_we    = bwd_ok;
        nxt_waddr = bwd_a;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      row_sel_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
      if (in_xfer) begin
        row_sel_r <= row_sel_r ^ in_ch.new_line;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_RD1: begin
        pix_sum_r <= ERR_W'(pix_r) + (col_ok ? ERR_W'($signed(cur_rdata)) : '0);
        e_n1_r    <= nxt_rdata;
      end
      ST_QNT: begin
        e_c7_r <= cur_rdata;
        e_n5_r <= nxt_rdata;
        n_r    <= N_W'(pix_sum_r) * N_W'(lv_eff) + N_W'(QUANT_BIAS);
      end
      ST_QV: begin
        e_n3_r <= nxt_rdata;
        v_r    <= v_nxt;
      end
      default: ;
    endcase
    if (push) begin
      err_r       <= pix_sum_r - ERR_W'(div_rsp.quot);
      out_level_r <= v_r;
    end
    prod_r <= PROD_W'(err_r) * PROD_W'(w_sel);
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.level = out_level_r;

  // --------------------------------------------------------------------------
  // line stores
  // --------------------------------------------------------------------------
  assign cur_rdata = row_sel_r ? b_rdata : a_rdata;
  assign nxt_rdata = row_sel_r ? a_rdata : b_rdata;

  always_comb begin
    if (state_r == ST_CLEAR) begin
      a_we    = 1'b1;
      b_we    = 1'b1;
      a_waddr = clr_cnt_r;
      b_waddr = clr_cnt_r;
      a_wdata = '0;
      b_wdata = '0;
    end else begin
      a_we    = row_sel_r ? nxt_we : cur_we;
      b_we    = row_sel_r ? cur_we : nxt_we;
      a_waddr = row_sel_r ? nxt_waddr : cur_waddr;
      b_waddr = row_sel_r ? cur_waddr : nxt_waddr;
      a_wdata = row_sel_r ? nxt_wdata : cur_wdata;
      b_wdata = row_sel_r ? cur_wdata : nxt_wdata;
    end
    a_raddr = row_sel_r ? nxt_raddr : cur_raddr;
    b_raddr = row_sel_r ? cur_raddr : nxt_raddr;
  end

  edh_ram #(
    .WIDTH (ERROR_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_row_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  edh_ram #(
    .WIDTH (ERROR_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_row_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  `EDH_ASSERT_IMP(a_level_in_range, out_valid_r, out_level_r <= lv_eff, "level above levels")
  `EDH_ASSERT_IMP(a_no_write_idle, state_r == ST_IDLE, !(a_we || b_we), "store written in idle")
  `EDH_ASSERT_NXT(a_one_item, in_xfer, !in_ch.ready, "second pixel taken during processing")

endmodule

`default_nettype wire
